// File: sv/i2rt_pkg.sv
// ----------------------------------------------------------------------------
// i2rt_pkg - shared definitions for the integer to radix text converter
// Sequencer states, register limits, character codes and the digit lookup.
// ----------------------------------------------------------------------------
package i2rt_pkg;

	localparam int unsigned VALUE_BITS_DEF = 32;
	localparam int unsigned RADIX_W        = 6;
	localparam int unsigned CHAR_W         = 8;

	// Quotient bits produced by the shared divider in one cycle
	localparam int unsigned STEP_BITS      = 4;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;

	localparam logic [CHAR_W-1:0] MINUS_CHAR   = 8'h2D;
	localparam logic [CHAR_W-1:0] ZERO_CHAR    = 8'h30;
	localparam logic [CHAR_W-1:0] ALPHA_CHAR   = 8'h41;
	localparam logic [RADIX_W-1:0] DIGIT_TEN   = 6'd10;
	localparam logic [RADIX_W-1:0] DIGIT_TOP   = 6'd35;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_EMIT
	} i2rt_state_t;

	// Map a digit value to '0'-'9' or 'A'-'Z'; values past 35 show as 'Z'
	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [RADIX_W-1:0] c;
		c = (d > DIGIT_TOP) ? DIGIT_TOP : d;
		if (c < DIGIT_TEN)
			return ZERO_CHAR + CHAR_W'(c);
		else
			return ALPHA_CHAR + CHAR_W'(c - DIGIT_TEN);
	endfunction

endpackage

// File: sv/integer_to_radix_text.sv
// ----------------------------------------------------------------------------
// integer_to_radix_text - signed integer to ASCII text in radix 2 to 36
// Converts one integer per request into its digit characters, most
// significant first, with the final character flagged by last.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/value) takes one request at a time.
//   in_ready is high only while the sequencer is idle; it may be high while
//   the final character of the previous request still waits at the output.
//   Output channel (out_valid/out_ready/character/last) carries one ASCII
//   character per transfer; last marks the final digit of a request.
//   radix_wr_en/radix writes the number base; writes below 2 or above 36 are
//   clamped. Only in radix 10 does a negative value get a leading '-'.
// Conversion:
//   A shared restoring divider makes STEP_BITS quotient bits per cycle, so
//   each digit takes one full pass of the dividend through the divider.
//   A request is divided digit by digit; then its characters ('-' first,
//   if any) are sent, and no new request is taken until its final
//   character has been loaded into the output register.
// Reset and stall:
//   arst_n clears the sequencer and output valid and sets the radix to 10.
//   A stalled receiver holds the output register and pauses the digit
//   readout; the division phase does not depend on out_ready.
// ----------------------------------------------------------------------------
module integer_to_radix_text #(
	parameter int unsigned VALUE_BITS = i2rt_pkg::VALUE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          radix_wr_en,
	input  logic [i2rt_pkg::RADIX_W-1:0]  radix,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [VALUE_BITS-1:0]  value,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [i2rt_pkg::CHAR_W-1:0]   character,
	output logic                          last
);
	import i2rt_pkg::*;

	localparam int unsigned STEPS      = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
	localparam int unsigned DIV_W      = STEPS * STEP_BITS;
	localparam int unsigned STEP_CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;
	localparam int unsigned IDX_W      = $clog2(VALUE_BITS);
	localparam logic [STEP_CNT_W-1:0] STEP_LAST = STEP_CNT_W'(STEPS - 1);
	localparam logic [IDX_W-1:0]      IDX_LAST  = IDX_W'(VALUE_BITS - 1);

	i2rt_state_t state_q, state_nxt;

	logic [RADIX_W-1:0]    radix_q;
	logic [DIV_W-1:0]      div_q;        // dividend shifting out, quotient in
	logic [RADIX_W-1:0]    rem_q;        // partial remainder, below radix
	logic [STEP_CNT_W-1:0] step_q;
	logic [IDX_W-1:0]      wr_idx_q;
	logic [IDX_W-1:0]      rd_idx_q;
	logic                  sign_pend_q;  // '-' still to be sent
	logic                  out_valid_q;
	logic [CHAR_W-1:0]     char_q;
	logic                  last_q;

	// Digit store, least significant digit first
	logic [RADIX_W-1:0]    digit_mem [VALUE_BITS];

	logic [DIV_W-1:0]      div_nxt;
	logic [RADIX_W-1:0]    rem_nxt;
	logic [VALUE_BITS-1:0] mag;
	logic                  is_neg;
	logic                  start;
	logic                  digit_done;
	logic                  conv_done;
	logic                  load_out;
	logic                  emit_end;

	// Shared divider: STEP_BITS restoring steps on the narrow remainder
	always_comb begin
		logic [RADIX_W:0] trial;
		div_nxt = div_q;
		rem_nxt = rem_q;
		for (int j = 0; j < int'(STEP_BITS); j++) begin
			trial = {rem_nxt, div_nxt[DIV_W-1]};
			if (trial >= {1'b0, radix_q}) begin
				rem_nxt = RADIX_W'(trial - {1'b0, radix_q});
				div_nxt = {div_nxt[DIV_W-2:0], 1'b1};
			end else begin
				rem_nxt = trial[RADIX_W-1:0];
				div_nxt = {div_nxt[DIV_W-2:0], 1'b0};
			end
		end
	end

	// Sign handling: only decimal shows a minus sign
	assign is_neg = (radix_q == RADIX_DEC) && value[VALUE_BITS-1];
	assign mag    = is_neg ? (VALUE_BITS'(0) - VALUE_BITS'(value)) : VALUE_BITS'(value);

	assign in_ready   = (state_q == ST_IDLE);
	assign start      = in_valid && in_ready;
	assign digit_done = (state_q == ST_DIVIDE) && (step_q == STEP_LAST);
	assign conv_done  = digit_done && ((div_nxt == '0) || (wr_idx_q == IDX_LAST));
	assign load_out   = (state_q == ST_EMIT) && (!out_valid_q || out_ready);
	assign emit_end   = load_out && !sign_pend_q && (rd_idx_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start)
					state_nxt = ST_DIVIDE;
			end
			ST_DIVIDE: begin
				if (conv_done)
					state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (emit_end)
					state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Radix register, clamped on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (radix_wr_en) begin
			if (radix < RADIX_MIN)
				radix_q <= RADIX_MIN;
			else if (radix > RADIX_MAX)
				radix_q <= RADIX_MAX;
			else
				radix_q <= radix;
		end
	end

	// Control state of the divider and readout
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			wr_idx_q    <= '0;
			rd_idx_q    <= '0;
			sign_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				step_q      <= '0;
				wr_idx_q    <= '0;
				sign_pend_q <= is_neg;
			end else if (state_q == ST_DIVIDE) begin
				step_q <= digit_done ? '0 : step_q + 1'b1;
				if (conv_done)
					rd_idx_q <= wr_idx_q;
				else if (digit_done)
					wr_idx_q <= wr_idx_q + 1'b1;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
				if (sign_pend_q)
					sign_pend_q <= 1'b0;
				else if (rd_idx_q != '0)
					rd_idx_q <= rd_idx_q - 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath: dividend, remainder, digit store and output register
	always_ff @(posedge clk) begin
		if (start) begin
			div_q <= DIV_W'(mag);
			rem_q <= '0;
		end else if (state_q == ST_DIVIDE) begin
			div_q <= div_nxt;
			// start the next digit from a clear remainder
			rem_q <= digit_done ? '0 : rem_nxt;
			if (digit_done)
				digit_mem[wr_idx_q] <= rem_nxt;
		end
		if (load_out) begin
			if (sign_pend_q) begin
				char_q <= MINUS_CHAR;
				last_q <= 1'b0;
			end else begin
				char_q <= digit_char(digit_mem[rd_idx_q]);
				last_q <= (rd_idx_q == '0);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

`ifndef SYNTHESIS
	a_rem_below_radix: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE) |-> (rem_q < radix_q))
		else $error("divider remainder not below radix");

	a_start_divides: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_DIVIDE))
		else $error("accepted request did not enter division");

	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (character == MINUS_CHAR)) |-> !last)
		else $error("minus sign flagged as last character");

	a_end_flags_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit_end |=> (state_q == ST_IDLE) && out_valid && last)
		else $error("final digit not flagged or sequencer not idle");
`endif

endmodule

// File: tb/tb_integer_to_radix_text.sv
// ----------------------------------------------------------------------------
// tb_integer_to_radix_text - self-checking bench for the radix text converter
// Feeds signed integers through the valid/ready input, predicts the ASCII
// digit stream for the current radix and checks every output character and
// last flag in order, across several radix settings and pacing patterns.
// ----------------------------------------------------------------------------
module tb_integer_to_radix_text;

	import i2rt_pkg::*;

	localparam int CLK_HALF     = 4;
	localparam int RESET_CYCLES = 2;
	// Cycles to let pass once the output is quiet; covers a full radix 2 request
	localparam int DRAIN_GAP    = 300;
	// Long receiver hold-off used to back the block up onto its input
	localparam int HOLD_LEN     = 400;
	localparam int LIMIT_CYCLES = 2_000_000;

	localparam string DIGIT_SET = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";

	typedef enum logic [2:0] {
		PACE_FULL,
		PACE_SEND_GAPS,
		PACE_RECV_STALLS,
		PACE_BOTH,
		PACE_HOLD_OFF
	} pace_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              fin;
	} text_char_t;

	logic                     clk         = 1'b0;
	logic                     arst_n      = 1'b0;
	logic                     radix_wr_en = 1'b0;
	logic [RADIX_W-1:0]       radix_data  = '0;
	logic                     in_valid    = 1'b0;
	logic                     in_ready;
	logic signed [31:0]       value_in    = '0;
	logic                     out_valid;
	logic                     out_ready   = 1'b0;
	logic [CHAR_W-1:0]        character;
	logic                     last;

	// Testbench copy of the radix register, always held in the legal range
	logic [RADIX_W-1:0]       radix_now   = RADIX_RESET;
	pace_t                    pace        = PACE_FULL;

	logic [31:0]              pending_values[$];
	text_char_t               expected_text[$];

	int                       hold_count     = 0;
	int                       cycle_count    = 0;
	int                       mismatch_count = 0;
	int                       values_sent    = 0;
	int                       chars_seen     = 0;
	int                       radix_writes   = 0;

	integer_to_radix_text dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.radix_wr_en (radix_wr_en),
		.radix       (radix_data),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.value       (value_in),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.character   (character),
		.last        (last)
	);

	initial begin
		forever #CLK_HALF clk = ~clk;
	end

	// Build the expected character stream for one accepted request. Decimal
	// negatives get a leading minus and their magnitude (the most negative
	// value wraps to 2^31); every other radix reads the bits as unsigned.
	function automatic void predict_text(input logic [31:0] v);
		logic [31:0]        mag;
		logic               negative;
		logic [RADIX_W-1:0] digs [32];
		int                 n;
		text_char_t         c;
		negative = (radix_now == RADIX_DEC) && v[31];
		mag = negative ? (32'd0 - v) : v;
		n = 0;
		do begin
			digs[n] = RADIX_W'(mag % radix_now);
			n++;
			mag = mag / radix_now;
		end while (mag != 0);
		if (negative) begin
			c.ch  = MINUS_CHAR;
			c.fin = 1'b0;
			expected_text.push_back(c);
		end
		for (int k = n - 1; k >= 0; k--) begin
			c.ch  = DIGIT_SET[digs[k]];
			c.fin = (k == 0);
			expected_text.push_back(c);
		end
	endfunction

	// Random value with a spread of magnitudes, signs and extremes
	function automatic logic [31:0] next_value();
		logic [31:0] v;
		case ($urandom_range(0, 5))
			0: v = $urandom;
			1: v = $urandom_range(0, 40);
			2: v = 32'd0 - $urandom_range(1, 40);
			3: begin
				case ($urandom_range(0, 3))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'hFFFF_FFFF;
					default: v = 32'h0;
				endcase
			end
			4: v = $urandom >> $urandom_range(0, 31);
			default: v = 32'd0 - ($urandom >> $urandom_range(0, 31));
		endcase
		return v;
	endfunction

	// Request driver: hold valid and payload until accepted, predict on the
	// accepting edge, then either offer the next pending value or idle.
	always @(posedge clk or negedge arst_n) begin
		logic accepted;
		logic gap;
		if (!arst_n) begin
			in_valid <= 1'b0;
			value_in <= '0;
		end else begin
			accepted = in_valid && in_ready;
			if (accepted) begin
				predict_text(value_in);
				values_sent++;
			end
			if (!in_valid || accepted) begin
				case (pace)
					PACE_SEND_GAPS: gap = ($urandom_range(0, 99) < 79);
					PACE_BOTH:      gap = ($urandom_range(0, 99) < 37);
					default:        gap = 1'b0;
				endcase
				if (pending_values.size() != 0 && !gap) begin
					in_valid <= 1'b1;
					value_in <= pending_values.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Output ready: random stalls per pacing mode; in hold-off mode hold ready
	// low until hold_count reaches HOLD_LEN so the block backs up and stalls its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready  <= 1'b0;
			hold_count <= 0;
		end else begin
			if (pace == PACE_HOLD_OFF) begin
				if (hold_count < HOLD_LEN)
					hold_count <= hold_count + 1;
			end else begin
				hold_count <= 0;
			end
			case (pace)
				PACE_RECV_STALLS: out_ready <= ($urandom_range(0, 99) >= 79);
				PACE_BOTH:        out_ready <= ($urandom_range(0, 99) >= 37);
				PACE_HOLD_OFF:    out_ready <= (hold_count >= HOLD_LEN);
				default:          out_ready <= 1'b1;
			endcase
		end
	end

	// Character checker: compare each transfer against the oldest prediction
	always @(posedge clk) begin
		text_char_t want;
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			chars_seen++;
			if (expected_text.size() == 0) begin
				$display("%0t: unexpected character: expected none, actual %h last %b",
					$time, character, last);
				mismatch_count++;
			end else begin
				want = expected_text.pop_front();
				if (character !== want.ch) begin
					$display("%0t: character mismatch: expected %h, actual %h",
						$time, want.ch, character);
					mismatch_count++;
				end
				if (last !== want.fin) begin
					$display("%0t: last mismatch: expected %b, actual %b",
						$time, want.fin, last);
					mismatch_count++;
				end
			end
		end
	end

	// Hang guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Write the radix register while the block is idle; track the clamped value
	task automatic write_radix(input logic [RADIX_W-1:0] v);
		@(posedge clk);
		radix_wr_en <= 1'b1;
		radix_data  <= v;
		@(posedge clk);
		radix_wr_en <= 1'b0;
		radix_now = (v < RADIX_MIN) ? RADIX_MIN : ((v > RADIX_MAX) ? RADIX_MAX : v);
		radix_writes++;
	endtask

	// Wait until every request has gone in and every character has come out
	task automatic wait_for_drain();
		do @(negedge clk);
		while (pending_values.size() != 0 || in_valid || expected_text.size() != 0);
		repeat (DRAIN_GAP) @(negedge clk);
	endtask

	task automatic run_random(input logic [RADIX_W-1:0] wr, input pace_t p, input int n);
		write_radix(wr);
		pace = p;
		repeat (n) pending_values.push_back(next_value());
		wait_for_drain();
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Decimal at the reset radix: zero, signs, extremes, wrap of INT_MIN
		pace = PACE_FULL;
		pending_values.push_back(32'd0);
		pending_values.push_back(32'd1);
		pending_values.push_back(32'hFFFF_FFFF);
		pending_values.push_back(32'd9);
		pending_values.push_back(32'd10);
		pending_values.push_back(32'd0 - 32'd10);
		pending_values.push_back(32'h7FFF_FFFF);
		pending_values.push_back(32'h8000_0000);
		pending_values.push_back(32'd1000000000);
		pending_values.push_back(32'd0 - 32'd123456789);
		wait_for_drain();

		// Write of zero clamps to binary: longest texts, no minus sign
		write_radix(6'd0);
		pending_values.push_back(32'd0);
		pending_values.push_back(32'd1);
		pending_values.push_back(32'hFFFF_FFFF);
		pending_values.push_back(32'h8000_0000);
		pending_values.push_back(32'h5555_5555);
		wait_for_drain();

		// All-ones write clamps to 36: letter digits up to 'Z'
		write_radix(6'h3F);
		pending_values.push_back(32'd35);
		pending_values.push_back(32'd36);
		pending_values.push_back(32'hFFFF_FFFF);
		pending_values.push_back(32'd1295);
		wait_for_drain();

		write_radix(6'd16);
		pending_values.push_back(32'hDEAD_BEEF);
		pending_values.push_back(32'h0000_000F);
		wait_for_drain();

		// Random phases over radix settings and pacing patterns
		run_random(6'd10, PACE_SEND_GAPS, 45);
		run_random(6'd1, PACE_RECV_STALLS, 15);
		run_random(6'd37, PACE_BOTH, 35);
		run_random(6'd16, PACE_FULL, 35);
		run_random(6'd7, PACE_SEND_GAPS, 25);
		run_random(6'd10, PACE_HOLD_OFF, 30);
		run_random(6'd3, PACE_RECV_STALLS, 20);
		run_random(RADIX_W'($urandom_range(2, 36)), PACE_BOTH, 25);
		run_random(6'd10, PACE_BOTH, 40);

		$display("Summary: %0d values converted into %0d characters over %0d radix writes,",
			values_sent, chars_seen, radix_writes);
		$display("  covering clamped writes, radix 2 to 36, random gaps and a long output hold-off.");
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: sim.f
sv/i2rt_pkg.sv
sv/integer_to_radix_text.sv
tb/tb_integer_to_radix_text.sv
